// ===== rtl/core/cms_pkg.sv =====
`default_nettype none
package cms_pkg;
    localparam int ROWS_DEF         = 4;
    localparam int COLUMNS_DEF      = 1024;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int HASH_W           = 32;
    localparam int AMOUNT_W         = 16;
    localparam int EST_W            = 16;
    localparam int ROWS_CFG_W       = 3;
    localparam int COLS_CFG_W       = 11;
    localparam int ROWS_RESET       = 4;
    localparam int COLS_RESET       = 1024;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [0:0] REG_ROWS = 1'd0;
    localparam logic [0:0] REG_COLS = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_WAIT,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic mod_step;
        logic rd;
        logic wr;
        logic next_row;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic last_row;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/count_min_sketch_unit.sv =====
`default_nettype none
// Count-min sketch unit.
// Items enter on start while busy is low: action, one hash per row, amount.
// Actions: insert (saturating add), delete (floored subtract), point query.
// Action code 3 passes through the sequence and changes nothing.
// Each row's column is its hash modulo columns_in_use, found by a restoring
// divider that retires one hash bit per cycle. Per row: the modulo steps, then
// read, wait and write of the row memory; a done step ends the item, and busy
// covers all of it.
// A query drives o_estimate with o_done high for one cycle, the first cycle
// with busy low again; the receiver cannot stall and must take it then.
// Configuration: APB, rows_in_use at 0x0, columns_in_use at 0x4; the user
// must write them only while idle, which the block does not enforce. Reads
// return the register values. Reset: registers take their defaults and a
// clearing pass zeroes the counter memory, one entry per cycle, for all
// ROWS*COLUMNS entries (4096 by default), with busy held high.
module count_min_sketch_unit
    import cms_pkg::*;
#(
    parameter int ROWS         = ROWS_DEF,
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_action,
    input  wire logic [HASH_W-1:0]   i_hash_row0,
    input  wire logic [HASH_W-1:0]   i_hash_row1,
    input  wire logic [HASH_W-1:0]   i_hash_row2,
    input  wire logic [HASH_W-1:0]   i_hash_row3,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    output logic                     o_done,
    output logic [EST_W-1:0]         o_estimate,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [ROWS_CFG_W-1:0] r_rows;
    logic [COLS_CFG_W-1:0] r_cols;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_CFG_W'(ROWS_RESET);
            r_cols <= COLS_CFG_W'(COLS_RESET);
        end else if (w_wr) begin
            case (paddr[2:2])
                REG_ROWS: r_rows <= pwdata[ROWS_CFG_W-1:0];
                REG_COLS: r_cols <= pwdata[COLS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2:2])
                REG_ROWS: prdata = 32'(r_rows);
                REG_COLS: prdata = 32'(r_cols);
                default:  prdata = '0;
            endcase
        end
    end

    cms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    cms_datapath #(
        .ROWS         (ROWS),
        .COLUMNS      (COLUMNS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_action         (i_action),
        .i_hash_row0      (i_hash_row0),
        .i_hash_row1      (i_hash_row1),
        .i_hash_row2      (i_hash_row2),
        .i_hash_row3      (i_hash_row3),
        .i_amount         (i_amount),
        .i_rows_in_use    (r_rows),
        .i_columns_in_use (r_cols),
        .o_status         (w_status),
        .o_result_valid   (o_done),
        .o_estimate       (o_estimate)
    );
endmodule
`default_nettype wire

// ===== rtl/core/cms_ctrl.sv =====
`default_nettype none
module cms_ctrl
    import cms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output logic         o_busy,
    output t_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MOD;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                if (i_status.last_row) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.next_row = 1'b1;
                    n_state        = ST_MOD;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/cms_datapath.sv =====
`default_nettype none
module cms_datapath
    import cms_pkg::*;
#(
    parameter int ROWS         = ROWS_DEF,
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [1:0]            i_action,
    input  wire logic [HASH_W-1:0]     i_hash_row0,
    input  wire logic [HASH_W-1:0]     i_hash_row1,
    input  wire logic [HASH_W-1:0]     i_hash_row2,
    input  wire logic [HASH_W-1:0]     i_hash_row3,
    input  wire logic [AMOUNT_W-1:0]   i_amount,
    input  wire logic [ROWS_CFG_W-1:0] i_rows_in_use,
    input  wire logic [COLS_CFG_W-1:0] i_columns_in_use,
    output t_status                    o_status,
    output logic                       o_result_valid,
    output logic [EST_W-1:0]           o_estimate
);
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int NCOL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STEP_W  = $clog2(HASH_W + 1);
    localparam int SUM_W   = (COUNTER_BITS > AMOUNT_W ? COUNTER_BITS : AMOUNT_W) + 1;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [SUM_W-1:0] CTR_MAX_W = SUM_W'(CTR_MAX);

    logic [COUNTER_BITS-1:0] r_mem [DEPTH];
    logic [COUNTER_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [1:0]              r_action;
    logic [AMOUNT_W-1:0]     r_amount;
    logic [HASH_W-1:0]       r_hash [4];
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W:0]          r_nrows;
    logic [NCOL_W-1:0]       r_ncols;
    logic [HASH_W-1:0]       r_quot;
    logic [NCOL_W-1:0]       r_rem;
    logic [STEP_W-1:0]       r_step;
    logic [COUNTER_BITS-1:0] r_best;
    logic                    r_valid;
    logic [EST_W-1:0]        r_est;

    logic [NCOL_W-1:0] w_ncols;
    logic [ROW_W:0]    w_nrows;
    logic [NCOL_W:0]   w_shift;
    logic [NCOL_W:0]   w_sub;
    logic [ADDR_W-1:0] w_addr;
    logic [SUM_W-1:0]  w_sum;
    logic [COUNTER_BITS-1:0] w_new;
    logic [1:0]        w_row_idx;

    always_comb begin
        if (i_columns_in_use == '0) begin
            w_ncols = NCOL_W'(1);
        end else if (32'(i_columns_in_use) > 32'(COLUMNS)) begin
            w_ncols = NCOL_W'(COLUMNS);
        end else begin
            w_ncols = NCOL_W'(i_columns_in_use);
        end
        if (i_rows_in_use == '0) begin
            w_nrows = (ROW_W+1)'(1);
        end else if (32'(i_rows_in_use) > 32'(ROWS)) begin
            w_nrows = (ROW_W+1)'(ROWS);
        end else begin
            w_nrows = (ROW_W+1)'(i_rows_in_use);
        end
    end

    assign w_shift   = {r_rem, r_quot[HASH_W-1]};
    assign w_sub     = w_shift - {1'b0, r_ncols};
    assign w_addr    = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_rem));
    assign w_row_idx = 2'(r_row);

    always_comb begin
        w_sum = '0;
        w_new = r_rdata;
        if (r_action == ACT_INSERT) begin
            w_sum = SUM_W'(r_rdata) + SUM_W'(r_amount);
            w_new = (w_sum >= CTR_MAX_W) ? CTR_MAX : w_sum[COUNTER_BITS-1:0];
        end else if (r_action == ACT_DELETE) begin
            w_new = (SUM_W'(r_amount) >= SUM_W'(r_rdata)) ? '0
                  : COUNTER_BITS'(SUM_W'(r_rdata) - SUM_W'(r_amount));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr && r_action != ACT_QUERY) begin
            r_mem[w_addr] <= w_new;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_amount <= i_amount;
            r_hash[0] <= i_hash_row0;
            r_hash[1] <= i_hash_row1;
            r_hash[2] <= i_hash_row2;
            r_hash[3] <= i_hash_row3;
            r_nrows  <= w_nrows;
            r_ncols  <= w_ncols;
            r_row    <= '0;
            r_best   <= CTR_MAX;
            r_quot   <= i_hash_row0;
            r_rem    <= '0;
            r_step   <= '0;
        end else begin
            if (i_cmd.mod_step) begin
                r_quot <= {r_quot[HASH_W-2:0], 1'b0};
                r_rem  <= w_sub[NCOL_W] ? w_shift[NCOL_W-1:0] : w_sub[NCOL_W-1:0];
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.wr && r_action == ACT_QUERY && r_rdata < r_best) begin
                r_best <= r_rdata;
            end
            if (i_cmd.next_row) begin
                r_row  <= r_row + ROW_W'(1);
                r_quot <= r_hash[w_row_idx + 2'd1];
                r_rem  <= '0;
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish && r_action == ACT_QUERY;
        end
        if (i_cmd.finish) begin
            r_est <= (32'(r_best) > 32'hFFFF) ? '1 : EST_W'(r_best);
        end
    end

    assign o_status = {(32'(r_clr_addr) == DEPTH - 1),
                       (32'(r_step) == HASH_W - 1),
                       ((ROW_W+1)'(r_row) + (ROW_W+1)'(1) >= r_nrows)};
    assign o_result_valid = r_valid;
    assign o_estimate     = r_est;
endmodule
`default_nettype wire

// ===== verif/count_min_sketch_unit_test.sv =====
`default_nettype none
module count_min_sketch_unit_test;
    import cms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = ROWS_DEF;
    localparam int NCOLS = COLUMNS_DEF;
    localparam logic [15:0] CTR_MAX = 16'hFFFF;
    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [15:0] amount;
    } t_sketch_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] i_action = '0;
    logic [31:0] i_hash_row0 = '0, i_hash_row1 = '0, i_hash_row2 = '0, i_hash_row3 = '0;
    logic [15:0] i_amount = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire busy, o_done, pready;
    wire [15:0] o_estimate;
    wire [31:0] prdata;

    count_min_sketch_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    logic [15:0] sketch_mem [NROWS][NCOLS];
    int unsigned rows_cfg, cols_cfg;
    t_sketch_item pending_items[$];
    logic [15:0] expected_estimates[$];
    int mismatches = 0;
    int burst_left = 0, gap_left = 0;

    function automatic void predict_item(t_sketch_item it);
        int unsigned nr, nc, col;
        logic [31:0] h;
        logic [16:0] sum;
        logic [15:0] cur, best;
        nr = (rows_cfg < 1) ? 1 : (rows_cfg > NROWS ? NROWS : rows_cfg);
        nc = (cols_cfg < 1) ? 1 : (cols_cfg > NCOLS ? NCOLS : cols_cfg);
        best = CTR_MAX;
        if (it.action == ACT_UNUSED) return;
        for (int r = 0; r < nr; r++) begin
            h = (r == 0) ? it.h0 : (r == 1) ? it.h1 : (r == 2) ? it.h2 : it.h3;
            col = h % nc;
            cur = sketch_mem[r][col];
            if (it.action == ACT_INSERT) begin
                sum = {1'b0, cur} + {1'b0, it.amount};
                sketch_mem[r][col] = sum[16] ? CTR_MAX : sum[15:0];
            end else if (it.action == ACT_DELETE) begin
                sketch_mem[r][col] = (it.amount >= cur) ? 16'd0 : cur - it.amount;
            end else if (cur < best) begin
                best = cur;
            end
        end
        if (it.action == ACT_QUERY) expected_estimates.push_back(best);
    endfunction

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            predict_item({i_action, i_hash_row0, i_hash_row1, i_hash_row2, i_hash_row3,
                          i_amount});
        end
        if (!i_rst_n || (start && !busy)) begin
            start <= 1'b0;
            if (i_rst_n && pending_items.size() > 0 && burst_left > 0) begin
                t_sketch_item it;
                it = pending_items.pop_front();
                {i_action, i_hash_row0, i_hash_row1, i_hash_row2, i_hash_row3, i_amount} <= it;
                start <= 1'b1;
                burst_left <= burst_left - 1;
            end
        end else if (!start && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 8);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
            end else if (pending_items.size() > 0) begin
                t_sketch_item it;
                it = pending_items.pop_front();
                {i_action, i_hash_row0, i_hash_row1, i_hash_row2, i_hash_row3, i_amount} <= it;
                start <= 1'b1;
                burst_left <= burst_left - 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected estimate %0d", o_estimate);
            end else begin
                logic [15:0] exp_est;
                exp_est = expected_estimates.pop_front();
                if (o_estimate !== exp_est) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("estimate mismatch: expected %0d actual %0d", exp_est,
                                 o_estimate);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_ROWS) rows_cfg = value & 32'h7;
        else if (addr == ADDR_COLS) cols_cfg = value & 32'h7FF;
    endtask

    task automatic drain_phase();
        while (pending_items.size() > 0 || start || busy || expected_estimates.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_sketch_item make_item(logic [1:0] act, logic [31:0] key, bit wide);
        t_sketch_item it;
        it.action = act;
        it.h0 = wide ? $urandom : key;
        it.h1 = wide ? $urandom : key * 3 + 1;
        it.h2 = wide ? $urandom : key * 7 + 5;
        it.h3 = wide ? $urandom : key ^ 32'hFFFF_FFFF;
        case ($urandom_range(0, 5))
            0: it.amount = 16'hFFFF;
            1: it.amount = 16'd0;
            2: it.amount = 16'($urandom);
            default: it.amount = 16'($urandom_range(1, 300));
        endcase
        return it;
    endfunction

    task automatic random_phase(int n_items, int unsigned nkeys);
        logic [31:0] keys [8];
        int pick;
        for (int k = 0; k < 8; k++) keys[k] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                pending_items.push_back(make_item(ACT_INSERT, keys[$urandom_range(0, nkeys-1)], 0));
            else if (pick < 55)
                pending_items.push_back(make_item(ACT_DELETE, keys[$urandom_range(0, nkeys-1)], 0));
            else if (pick < 90)
                pending_items.push_back(make_item(ACT_QUERY, keys[$urandom_range(0, nkeys-1)], 0));
            else
                pending_items.push_back(make_item(2'($urandom_range(0, 3)), 0, 1));
        end
        drain_phase();
    endtask

    initial begin
        t_sketch_item it;
        foreach (sketch_mem[r, c]) sketch_mem[r][c] = '0;
        rows_cfg = ROWS_RESET;
        cols_cfg = COLS_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        it = '{ACT_QUERY, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0};
        pending_items.push_back(it);
        it.action = ACT_INSERT; it.amount = 16'hFFFF; pending_items.push_back(it);
        it.amount = 16'h1; pending_items.push_back(it);
        it.action = ACT_QUERY; pending_items.push_back(it);
        it.action = ACT_UNUSED; pending_items.push_back(it);
        it.action = ACT_DELETE; it.amount = 16'h0001; pending_items.push_back(it);
        it.action = ACT_QUERY; pending_items.push_back(it);
        it.action = ACT_DELETE; it.amount = 16'hFFFF; pending_items.push_back(it);
        it.action = ACT_QUERY; pending_items.push_back(it);
        it.action = ACT_INSERT; it.amount = 16'h1234; pending_items.push_back(it);
        it.action = ACT_DELETE; it.amount = 16'h5555; pending_items.push_back(it);
        it.action = ACT_QUERY; pending_items.push_back(it);
        drain_phase();

        random_phase(90, 8);
        write_reg(ADDR_ROWS, 32'd1); write_reg(ADDR_COLS, 32'd1);
        random_phase(60, 4);
        write_reg(ADDR_ROWS, 32'd0); write_reg(ADDR_COLS, 32'd0);
        random_phase(40, 4);
        write_reg(ADDR_ROWS, 32'd7); write_reg(ADDR_COLS, 32'd2047);
        random_phase(80, 8);
        write_reg(ADDR_ROWS, 32'd2); write_reg(ADDR_COLS, 32'd13);
        random_phase(80, 8);
        write_reg(ADDR_ROWS, 32'd3); write_reg(ADDR_COLS, 32'h0000_FC05);
        random_phase(80, 6);
        write_reg(ADDR_ROWS, 32'hFFFF_FFF4); write_reg(ADDR_COLS, 32'd1024);
        random_phase(110, 8);

        if (mismatches == 0 && expected_estimates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== count_min_sketch_unit.f =====
rtl/core/cms_pkg.sv
rtl/core/cms_ctrl.sv
rtl/core/cms_datapath.sv
rtl/core/count_min_sketch_unit.sv
verif/count_min_sketch_unit_test.sv
